>>> rtl/scit_pkg.sv
// shared types, widths and codes of the sorted cost insert table
`default_nettype none
package scit_pkg;

	localparam int DEPTH    = 64;
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W    = $clog2(DEPTH + 1);
	localparam int COST_W   = 32;
	localparam int HANDLE_W = 16;
	localparam int POS_W    = 6;
	localparam int KIND_W   = 2;
	localparam int STAT_W   = 2;
	localparam int ENTRY_W  = COST_W + HANDLE_W;
	localparam int S_DATA_W = 56;
	localparam int M_DATA_W = 56;

	localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
	localparam logic [KIND_W-1:0] KIND_READ   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

	typedef struct packed {
		logic [HANDLE_W-1:0] handle;
		logic [COST_W-1:0]   cost;
	} entry_t;

endpackage
`default_nettype wire

>>> rtl/scit_ram.sv
// generic single write port ram with registered read
`default_nettype none
module scit_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     wr_en,
	input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
	input  wire logic [WIDTH-1:0]         wr_data,
	input  wire logic                     rd_en,
	input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic      [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule
`default_nettype wire

>>> rtl/sorted_cost_insert_table_unit.sv
// Sorted cost table of DEPTH entries (cost, handle) held in ascending cost order in a
// single-port-write RAM. One request at a time: s_tready is high only while the
// sequencer is idle. An insert walks the table from its tail toward the head, one entry
// at a time (RAM read, then compare against the new cost and move the entry up one
// slot), and then writes the new entry; an insert into an empty table writes it directly.
// A read does one RAM read; a clear, a refused insert, an out-of-range read or an
// unused kind go straight to the final state. The single RAM port and its registered
// read set this pace. A result still waiting in the output register holds the
// sequencer in its final state until the result is taken. The table contents need no
// clearing after reset: only ranks below the count are ever read.
`default_nettype none
module sorted_cost_insert_table_unit
	import scit_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	// cost [31:0], handle [47:32], position [53:48], zero [55:54]
	input  wire logic [S_DATA_W-1:0] s_tdata,
	// kind [1:0]
	input  wire logic [KIND_W-1:0]   s_tuser,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	// read_handle [15:0], read_cost [47:16], count [54:48], zero [55]
	output logic      [M_DATA_W-1:0] m_tdata,
	// status [1:0]
	output logic      [STAT_W-1:0]   m_tuser
);

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_RD   = 3'd1;
	localparam logic [2:0] ST_EV   = 3'd2;
	localparam logic [2:0] ST_WRN  = 3'd3;
	localparam logic [2:0] ST_FIN  = 3'd4;

	logic [2:0]          state_q;
	logic [CNT_W-1:0]    count_q;
	logic [AW-1:0]       j_q;
	logic [AW-1:0]       at_q;
	logic                rd_mode_q;
	logic [COST_W-1:0]   cost_q;
	logic [HANDLE_W-1:0] handle_q;
	logic [STAT_W-1:0]   res_status_q;
	entry_t              res_entry_q;
	logic                m_tvalid_q;
	logic [M_DATA_W-1:0] m_tdata_q;
	logic [STAT_W-1:0]   m_tuser_q;

	logic [COST_W-1:0]   s_cost;
	logic [HANDLE_W-1:0] s_handle;
	logic [POS_W-1:0]    s_pos;
	logic                s_acc;
	logic                out_free;
	logic                shift_up;

	logic                ram_wr_en;
	logic [AW-1:0]       ram_wr_addr;
	entry_t              ram_wr_data;
	logic                ram_rd_en;
	entry_t              ram_rd_data;

	assign s_cost   = s_tdata[COST_W-1:0];
	assign s_handle = s_tdata[COST_W+HANDLE_W-1:COST_W];
	assign s_pos    = s_tdata[COST_W+HANDLE_W+POS_W-1:COST_W+HANDLE_W];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;

	// head moves only on a strict less, later entries on greater or equal
	assign shift_up = (j_q == '0) ? (ram_rd_data.cost > cost_q)
		: (ram_rd_data.cost >= cost_q);

	always_comb begin
		ram_wr_en   = 1'b0;
		ram_wr_addr = at_q;
		ram_wr_data = '{handle: handle_q, cost: cost_q};
		ram_rd_en   = (state_q == ST_RD);
		case (state_q)
			ST_EV: begin
				if (!rd_mode_q && shift_up) begin
					ram_wr_en   = 1'b1;
					ram_wr_addr = j_q + AW'(1);
					ram_wr_data = ram_rd_data;
				end
			end
			ST_WRN: begin
				ram_wr_en = 1'b1;
			end
			default: begin
				ram_wr_en = 1'b0;
			end
		endcase
	end

	scit_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_wr_en),
		.wr_addr (ram_wr_addr),
		.wr_data (ram_wr_data),
		.rd_en   (ram_rd_en),
		.rd_addr (j_q),
		.rd_data (ram_rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (s_acc) begin
						res_entry_q <= '0;
						case (s_tuser)
							KIND_INSERT: begin
								if (32'(count_q) >= DEPTH) begin
									res_status_q <= STAT_FULL;
									state_q      <= ST_FIN;
								end else if (count_q == '0) begin
									res_status_q <= STAT_OK;
									at_q         <= '0;
									state_q      <= ST_WRN;
								end else begin
									res_status_q <= STAT_OK;
									j_q          <= AW'(count_q - CNT_W'(1));
									state_q      <= ST_RD;
								end
							end
							KIND_READ: begin
								if (32'(s_pos) >= 32'(count_q)) begin
									res_status_q <= STAT_RANGE;
									state_q      <= ST_FIN;
								end else begin
									res_status_q <= STAT_OK;
									j_q          <= AW'(s_pos);
									state_q      <= ST_RD;
								end
							end
							KIND_CLEAR: begin
								res_status_q <= STAT_OK;
								count_q      <= '0;
								state_q      <= ST_FIN;
							end
							default: begin
								res_status_q <= STAT_OK;
								state_q      <= ST_FIN;
							end
						endcase
						rd_mode_q <= (s_tuser == KIND_READ);
						cost_q    <= s_cost;
						handle_q  <= s_handle;
					end
				end
				ST_RD: begin
					state_q <= ST_EV;
				end
				ST_EV: begin
					if (rd_mode_q) begin
						res_entry_q <= ram_rd_data;
						state_q     <= ST_FIN;
					end else if (shift_up) begin
						if (j_q == '0) begin
							at_q    <= '0;
							state_q <= ST_WRN;
						end else begin
							j_q     <= j_q - AW'(1);
							state_q <= ST_RD;
						end
					end else begin
						at_q    <= j_q + AW'(1);
						state_q <= ST_WRN;
					end
				end
				ST_WRN: begin
					count_q <= count_q + CNT_W'(1);
					state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// output register, loaded when the sequencer hands over a result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
			m_tdata_q  <= '0;
			m_tuser_q  <= '0;
		end else if (state_q == ST_FIN && out_free) begin
			m_tvalid_q <= 1'b1;
			m_tuser_q  <= res_status_q;
			m_tdata_q  <= M_DATA_W'({count_q, res_entry_q.cost, res_entry_q.handle});
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule
`default_nettype wire

>>> rtl/scit_chk.sv
// port-level checks of the sorted cost insert table and their bind
`default_nettype none
module scit_chk
	import scit_pkg::*;
(
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                s_tvalid,
	input wire logic                s_tready,
	input wire logic [KIND_W-1:0]   s_tuser,
	input wire logic                m_tvalid,
	input wire logic                m_tready,
	input wire logic [M_DATA_W-1:0] m_tdata,
	input wire logic [STAT_W-1:0]   m_tuser
);

	// a stalled result holds its payload
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("result changed while stalled");

	a_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tuser == STAT_OK || m_tuser == STAT_FULL
		|| m_tuser == STAT_RANGE)
		else $error("unknown status code");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_FULL |-> 32'(m_tdata[54:48]) == DEPTH)
		else $error("full refusal with table not full");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == STAT_RANGE |-> m_tdata[47:0] == '0)
		else $error("out of range read carries data");

	// a clear request comes back with an empty count
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tuser == KIND_CLEAR && !m_tvalid |=> ##1
		m_tvalid && m_tdata[54:48] == '0)
		else $error("clear did not empty the table");

endmodule

bind sorted_cost_insert_table_unit scit_chk u_scit_chk (.*);
`default_nettype wire

>>> test/tb_sorted_cost_insert_table_unit.sv
// testbench of the sorted cost insert table: directed and random stream traffic checked against a table model
`default_nettype none
module tb_sorted_cost_insert_table_unit;
	import scit_pkg::*;

	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
	localparam int ITEM_TARGET = 1950;
	localparam int PHASE_LEN   = 240;
	localparam int WATCHDOG    = 5000;
	localparam int TAIL_CYCLES = 200;

	typedef struct {
		logic [KIND_W-1:0]   kind;
		logic [COST_W-1:0]   cost;
		logic [HANDLE_W-1:0] handle;
		logic [POS_W-1:0]    position;
		bit                  drain;
		int                  phase;
	} table_req_t;

	typedef struct {
		logic [STAT_W-1:0]   status;
		logic [HANDLE_W-1:0] read_handle;
		logic [COST_W-1:0]   read_cost;
		logic [CNT_W-1:0]    count;
	} table_reply_t;

	logic                clk;
	logic                arst_n;
	logic                s_tvalid;
	logic                s_tready;
	logic [S_DATA_W-1:0] s_tdata;
	logic [KIND_W-1:0]   s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [STAT_W-1:0]   m_tuser;

	sorted_cost_insert_table_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// model of the table contents
	logic [COST_W-1:0]   tbl_cost [DEPTH];
	logic [HANDLE_W-1:0] tbl_handle [DEPTH];
	int                  tbl_count;

	table_req_t   req_q [$];
	table_reply_t reply_q [$];
	table_req_t   cur_req;
	bit           holding;
	bit           req_taken;
	logic         next_valid;
	int           send_idle_pct;
	int           recv_stall_pct;
	int           idle_cycles;
	int           results_seen;
	int           total_reqs;
	int           errors;
	int           drains;

	int n_insert, n_read, n_clear, n_unused, n_full, n_range, peak_count;

	// generator bookkeeping
	int gen_count;
	int gen_items;
	int gen_phase;
	bit gen_drain;

	function automatic table_reply_t table_step(table_req_t r);
		table_reply_t res;
		int at;
		int i;
		res.status      = STAT_OK;
		res.read_handle = '0;
		res.read_cost   = '0;
		case (r.kind)
			KIND_INSERT: begin
				n_insert++;
				if (tbl_count >= DEPTH) begin
					res.status = STAT_FULL;
					n_full++;
				end else begin
					// a cost tied with the head lands after it, a later tie lands in front
					if (tbl_count == 0 || r.cost < tbl_cost[0]) begin
						at = 0;
					end else begin
						at = 1;
						while (at < tbl_count && tbl_cost[at] < r.cost)
							at++;
					end
					for (i = tbl_count; i > at; i--) begin
						tbl_cost[i]   = tbl_cost[i-1];
						tbl_handle[i] = tbl_handle[i-1];
					end
					tbl_cost[at]   = r.cost;
					tbl_handle[at] = r.handle;
					tbl_count++;
					if (tbl_count > peak_count)
						peak_count = tbl_count;
				end
			end
			KIND_READ: begin
				n_read++;
				if (int'(r.position) >= tbl_count) begin
					res.status = STAT_RANGE;
					n_range++;
				end else begin
					res.read_handle = tbl_handle[r.position];
					res.read_cost   = tbl_cost[r.position];
				end
			end
			KIND_CLEAR: begin
				n_clear++;
				tbl_count = 0;
			end
			default: begin
				n_unused++;
			end
		endcase
		res.count = tbl_count[CNT_W-1:0];
		return res;
	endfunction

	task automatic push_req(input logic [KIND_W-1:0] kind, input logic [COST_W-1:0] cost,
			input logic [HANDLE_W-1:0] handle, input logic [POS_W-1:0] position);
		table_req_t r;
		r.kind     = kind;
		r.cost     = cost;
		r.handle   = handle;
		r.position = position;
		r.drain    = gen_drain;
		r.phase    = gen_phase;
		gen_drain  = 1'b0;
		req_q.push_back(r);
		if (kind != KIND_UNUSED)
			gen_items++;
		if (kind == KIND_INSERT && gen_count < DEPTH)
			gen_count++;
		else if (kind == KIND_CLEAR)
			gen_count = 0;
	endtask

	function automatic logic [COST_W-1:0] pick_cost(int style);
		case (style)
			0:       return COST_W'($urandom_range(15));
			1:       return COST_W'($urandom_range(1000));
			2:       return 32'hFFFF_FFF0 | COST_W'($urandom_range(15));
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [POS_W-1:0] pick_position();
		if (gen_count > 0 && $urandom_range(99) < 85)
			return POS_W'($urandom_range(gen_count - 1));
		return POS_W'($urandom_range(63));
	endfunction

	task automatic push_insert(int style);
		push_req(KIND_INSERT, pick_cost(style), HANDLE_W'($urandom), POS_W'($urandom));
	endtask

	task automatic push_read();
		push_req(KIND_READ, $urandom, HANDLE_W'($urandom), pick_position());
	endtask

	// driver: requests change at the falling edge, valid held until taken
	always @(negedge clk) begin
		if (arst_n) begin
			if (req_taken) begin
				holding   = 1'b0;
				req_taken = 1'b0;
				next_valid = 1'b0;
			end else begin
				next_valid = s_tvalid;
			end
			if (!holding && req_q.size() != 0
				&& !(req_q[0].drain && reply_q.size() != 0)) begin
				cur_req = req_q.pop_front();
				holding = 1'b1;
				if (cur_req.drain)
					drains++;
				case (cur_req.phase)
					0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
					1: begin send_idle_pct = 84; recv_stall_pct = 0;  end
					2: begin send_idle_pct = 0;  recv_stall_pct = 84; end
					default: begin send_idle_pct = 34; recv_stall_pct = 34; end
				endcase
			end
			if (!holding)
				next_valid = 1'b0;
			else if (!next_valid)
				next_valid = (send_idle_pct == 0) || ($urandom_range(99) >= send_idle_pct);
			s_tvalid <= next_valid;
			if (holding) begin
				s_tdata <= {2'b00, cur_req.position, cur_req.handle, cur_req.cost};
				s_tuser <= cur_req.kind;
			end
			m_tready <= (recv_stall_pct == 0) || ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// monitor: both handshakes sampled at the rising edge
	always @(posedge clk) begin
		if (arst_n) begin
			table_reply_t want;
			idle_cycles++;
			if (m_tvalid && m_tready) begin
				idle_cycles = 0;
				results_seen++;
				if (reply_q.size() == 0) begin
					$error("result with no request outstanding");
					errors++;
				end else begin
					want = reply_q.pop_front();
					if (m_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_tuser);
						errors++;
					end
					if (m_tdata[15:0] !== want.read_handle) begin
						$error("read_handle: expected %0h, got %0h", want.read_handle,
							m_tdata[15:0]);
						errors++;
					end
					if (m_tdata[47:16] !== want.read_cost) begin
						$error("read_cost: expected %0h, got %0h", want.read_cost,
							m_tdata[47:16]);
						errors++;
					end
					if (m_tdata[54:48] !== want.count) begin
						$error("count: expected %0d, got %0d", want.count, m_tdata[54:48]);
						errors++;
					end
				end
			end
			if (s_tvalid && s_tready) begin
				idle_cycles = 0;
				reply_q.push_back(table_step(cur_req));
				req_taken = 1'b1;
			end
			if (idle_cycles >= WATCHDOG) begin
				$display("watchdog: no handshake for %0d cycles, %0d results pending",
					WATCHDOG, reply_q.size());
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	initial begin
		int pick;
		int style;
		int n;
		int j;
		int next_phase_at;
		arst_n         = 1'b0;
		s_tvalid       = 1'b0;
		s_tdata        = '0;
		s_tuser        = '0;
		m_tready       = 1'b0;
		holding        = 1'b0;
		req_taken      = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		idle_cycles    = 0;
		results_seen   = 0;
		errors         = 0;
		drains         = 0;
		tbl_count      = 0;
		n_insert = 0; n_read = 0; n_clear = 0; n_unused = 0;
		n_full = 0; n_range = 0; peak_count = 0;
		gen_count = 0;
		gen_items = 0;
		gen_phase = 0;
		gen_drain = 1'b0;

		// directed: empty table, head and tie placement, cost and handle extremes
		push_req(KIND_READ, '0, '0, 6'd0);
		push_req(KIND_UNUSED, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F);
		push_req(KIND_INSERT, 32'd100, 16'h0000, '0);
		push_req(KIND_INSERT, 32'd50, 16'hFFFF, '0);
		push_req(KIND_INSERT, 32'd50, 16'h0001, '0);
		push_req(KIND_INSERT, 32'd100, 16'h0002, '0);
		push_req(KIND_INSERT, 32'hFFFF_FFFF, 16'h0003, '0);
		push_req(KIND_INSERT, 32'd0, 16'h0004, '0);
		push_req(KIND_INSERT, 32'd0, 16'h0005, '0);
		for (j = 0; j < 7; j++)
			push_req(KIND_READ, '0, '0, POS_W'(j));
		push_req(KIND_READ, '0, '0, 6'd7);
		push_req(KIND_READ, '0, '0, 6'h3F);
		push_req(KIND_UNUSED, '0, '0, '0);
		push_req(KIND_CLEAR, 32'hFFFF_FFFF, 16'hFFFF, 6'h3F);
		push_req(KIND_READ, '0, '0, 6'd0);
		push_req(KIND_CLEAR, '0, '0, '0);
		push_req(KIND_INSERT, 32'd7, 16'h0009, '0);
		push_req(KIND_READ, '0, '0, 6'd0);

		next_phase_at = gen_items;
		while (gen_items < ITEM_TARGET) begin
			if (gen_items >= next_phase_at) begin
				gen_phase     = (gen_phase + 1) % 4;
				gen_drain     = 1'b1;
				next_phase_at = next_phase_at + PHASE_LEN;
			end
			pick  = $urandom_range(99);
			style = $urandom_range(3);
			if (pick < 65) begin
				// fill and query with random content, sometimes past full
				push_req(KIND_CLEAR, $urandom, HANDLE_W'($urandom), POS_W'($urandom));
				n = ($urandom_range(9) == 0) ? $urandom_range(40, 70) : $urandom_range(1, 16);
				for (j = 0; j < n; j++) begin
					push_insert(style);
					if ($urandom_range(2) == 0)
						push_read();
				end
				repeat ($urandom_range(1, 4))
					push_read();
			end else if (pick < 70) begin
				push_req(KIND_CLEAR, '0, '0, '0);
				for (j = 0; j < DEPTH + 3; j++)
					push_insert(style);
				push_req(KIND_READ, '0, '0, 6'h3F);
				repeat (8)
					push_read();
				push_req(KIND_READ, '0, '0, 6'd0);
			end else begin
				// noise: any kind, any fields
				repeat ($urandom_range(1, 8)) begin
					n = $urandom_range(3);
					if (n == 1)
						push_read();
					else
						push_req(KIND_W'(n), pick_cost(style), HANDLE_W'($urandom),
							POS_W'($urandom));
				end
			end
		end
		total_reqs = req_q.size();

		// reset held low, then released at a falling edge
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (results_seen < total_reqs)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (reply_q.size() != 0) begin
			$error("%0d results never arrived", reply_q.size());
			errors++;
		end
		$display("covered %0d requests: %0d inserts (%0d refused full),",
			total_reqs, n_insert, n_full);
		$display("%0d reads (%0d out of range), %0d clears, %0d unused kinds,",
			n_read, n_range, n_clear, n_unused);
		$display("peak fill %0d of %0d, %0d drain pauses", peak_count, DEPTH, drains);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
`default_nettype wire
